@@ hdl/hsr_pkg.sv @@
// Package for the heap sort record block: sizes, record type, controller
// states, datapath operation codes and the command/status structs.
// No dependencies.
`default_nettype none

package hsr_pkg;

  // Store depth and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KID_W    = ADDR_W + 1;
  localparam int KEY_W    = 16;
  localparam int TAG_W    = 16;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_BLD_RD,
    ST_SRT_RD,
    ST_LOAD,
    ST_CHK,
    ST_CMP,
    ST_END,
    ST_EMIT,
    ST_FIN
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_PREP,
    OP_BLD_RD,
    OP_SRT_RD,
    OP_LOAD_BLD,
    OP_LOAD_SRT,
    OP_CHILD_RD,
    OP_PUT_NODE,
    OP_STEP,
    OP_DEC_START,
    OP_DEC_LAST,
    OP_EMIT_RD,
    OP_CLEAR
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_ge2;       // two or more records held
    logic has_child;   // current node has a child inside the heap
    logic swap;        // larger child beats the sinking record
    logic start_zero;  // build has reached the root
    logic last_one;    // sort pass is on the final exchange
    logic emit_zero;   // emit index is at the first entry
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/hsr_datapath.sv @@
// Datapath of the heap sort block: record memory (one write, two reads),
// index registers, compare logic and the registered result word.
// Depends on hsr_pkg.
`default_nettype none

module hsr_datapath (
  input  wire                    clk,
  input  wire                    rst_n,
  input  hsr_pkg::dp_cmd_t       cmd,
  input  wire [hsr_pkg::KEY_W-1:0] in_sort_key,
  input  wire [hsr_pkg::TAG_W-1:0] in_record_tag,
  output hsr_pkg::dp_stat_t      stat,
  output logic                   out_valid,
  output logic [hsr_pkg::KEY_W-1:0] out_key,
  output logic [hsr_pkg::TAG_W-1:0] out_tag,
  output logic                   out_last_result,
  output logic                   out_overflow_seen
);
  import hsr_pkg::*;

  rec_t              mem [CAPACITY];

  logic [CNT_W-1:0]  count_r;
  logic              dropped_r;
  logic [ADDR_W-1:0] node_r;
  logic [ADDR_W-1:0] bound_r;
  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] last_r;
  logic [ADDR_W-1:0] emit_r;
  logic [KID_W-1:0]  kid_r;
  rec_t              nodeval_r;
  rec_t              rd_a_r;
  rec_t              rd_b_r;
  logic              out_valid_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic [KID_W-1:0]  kid_calc;
  logic [KID_W-1:0]  kid_plus;
  logic [KID_W-1:0]  kid_r_plus;
  logic              use_b;
  rec_t              child;
  logic [ADDR_W-1:0] child_idx;
  logic              swap;
  logic              room;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [CNT_W-1:0]  cnt_half;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rec_t              wr_data;

  // Child selection: right child only when strictly greater
  always_comb begin
    kid_calc   = {node_r, 1'b1};
    kid_plus   = kid_calc + KID_W'(1);
    kid_r_plus = kid_r + KID_W'(1);
    use_b      = (kid_r < {1'b0, bound_r}) && (rd_a_r.key < rd_b_r.key);
    child      = use_b ? rd_b_r : rd_a_r;
    child_idx  = use_b ? kid_r_plus[ADDR_W-1:0] : kid_r[ADDR_W-1:0];
    swap       = nodeval_r.key < child.key;
    room       = count_r < CNT_W'(CAPACITY);
    cnt_m1     = count_r - CNT_W'(1);
    cnt_m2     = count_r - CNT_W'(2);
    cnt_half   = cnt_m2 >> 1;
  end

  // Status back to the controller
  always_comb begin
    stat.n_ge2      = count_r >= CNT_W'(2);
    stat.has_child  = kid_calc <= {1'b0, bound_r};
    stat.swap       = swap;
    stat.start_zero = start_r == '0;
    stat.last_one   = last_r == ADDR_W'(1);
    stat.emit_zero  = emit_r == '0;
  end

  // Memory port selection
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_en     = 1'b0;
    wr_addr   = node_r;
    wr_data   = nodeval_r;
    unique case (cmd.op)
      OP_STORE: begin
        wr_en   = room;
        wr_addr = count_r[ADDR_W-1:0];
        wr_data = '{key: in_sort_key, tag: in_record_tag};
      end
      OP_BLD_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = start_r;
      end
      OP_SRT_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = last_r;
      end
      OP_LOAD_SRT: begin
        // old root goes to the end of the heap
        wr_en   = 1'b1;
        wr_addr = last_r;
        wr_data = rd_b_r;
      end
      OP_CHILD_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = kid_calc[ADDR_W-1:0];
        rd_addr_b = kid_plus[ADDR_W-1:0];
      end
      OP_PUT_NODE: begin
        wr_en = 1'b1;
      end
      OP_STEP: begin
        wr_en   = 1'b1;
        wr_data = swap ? child : nodeval_r;
      end
      OP_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = emit_r;
      end
      default: begin
      end
    endcase
  end

  // Record memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // Batch count, drop flag and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      if (cmd.op == OP_STORE) begin
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end else if (cmd.op == OP_CLEAR) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end
      out_valid_r <= cmd.op == OP_EMIT_RD;
      out_last_r  <= (cmd.op == OP_EMIT_RD) && stat.emit_zero;
      out_ovf_r   <= (cmd.op == OP_EMIT_RD) && dropped_r;
    end
  end

  // Heap indices and the sinking record
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PREP: begin
        last_r  <= cnt_m1[ADDR_W-1:0];
        emit_r  <= cnt_m1[ADDR_W-1:0];
        start_r <= cnt_half[ADDR_W-1:0];
      end
      OP_BLD_RD: begin
        node_r  <= start_r;
        bound_r <= last_r;
      end
      OP_SRT_RD: begin
        node_r  <= '0;
        bound_r <= last_r - ADDR_W'(1);
      end
      OP_LOAD_BLD, OP_LOAD_SRT: begin
        nodeval_r <= rd_a_r;
      end
      OP_CHILD_RD: begin
        kid_r <= kid_calc;
      end
      OP_STEP: begin
        if (swap) begin
          node_r <= child_idx;
        end
      end
      OP_DEC_START: begin
        start_r <= start_r - ADDR_W'(1);
      end
      OP_DEC_LAST: begin
        last_r <= last_r - ADDR_W'(1);
      end
      OP_EMIT_RD: begin
        emit_r <= emit_r - ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_key           = rd_a_r.key;
  assign out_tag           = rd_a_r.tag;
  assign out_last_result   = out_last_r;
  assign out_overflow_seen = out_ovf_r;

endmodule

`default_nettype wire

@@ hdl/hsr_ctrl.sv @@
// Controller of the heap sort block: sequences load, heap build, sort
// passes and emission by issuing datapath operations.
// Depends on hsr_pkg.
`default_nettype none

module hsr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 in_final_item,
  input  hsr_pkg::dp_stat_t   stat,
  output hsr_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import hsr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   phase_r;    // 0: heap build, 1: sort passes
  logic   phase_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start && rst_n) begin
          cmd.op = OP_STORE;
          if (in_final_item) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.op    = OP_PREP;
        phase_nxt = 1'b0;
        state_nxt = stat.n_ge2 ? ST_BLD_RD : ST_EMIT;
      end
      ST_BLD_RD: begin
        cmd.op    = OP_BLD_RD;
        state_nxt = ST_LOAD;
      end
      ST_SRT_RD: begin
        cmd.op    = OP_SRT_RD;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.op    = phase_r ? OP_LOAD_SRT : OP_LOAD_BLD;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (stat.has_child) begin
          cmd.op    = OP_CHILD_RD;
          state_nxt = ST_CMP;
        end else begin
          cmd.op    = OP_PUT_NODE;
          state_nxt = ST_END;
        end
      end
      ST_CMP: begin
        cmd.op    = OP_STEP;
        state_nxt = stat.swap ? ST_CHK : ST_END;
      end
      ST_END: begin
        if (!phase_r) begin
          if (stat.start_zero) begin
            phase_nxt = 1'b1;
            state_nxt = ST_SRT_RD;
          end else begin
            cmd.op    = OP_DEC_START;
            state_nxt = ST_BLD_RD;
          end
        end else begin
          if (stat.last_one) begin
            state_nxt = ST_EMIT;
          end else begin
            cmd.op    = OP_DEC_LAST;
            state_nxt = ST_SRT_RD;
          end
        end
      end
      ST_EMIT: begin
        cmd.op = OP_EMIT_RD;
        if (stat.emit_zero) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.op    = OP_CLEAR;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE) || !rst_n;

endmodule

`default_nettype wire

@@ hdl/heap_sort_records.sv @@
// Top level of the heap sort block: joins the controller and the datapath.
// Depends on hsr_pkg, hsr_ctrl and hsr_datapath.
//
//   channel  | handshake            | words
//   ---------+----------------------+--------------------------------------------
//   input    | start & !busy        | in_sort_key, in_record_tag, in_final_item
//   result   | out_valid (1 cycle)  | out_key, out_tag, out_last_result,
//            |                      | out_overflow_seen
//
// A non-final word is stored while busy stays low, so the block is ready for the next word.
// After the final word: a setup state, then each sift-down reads and loads its record,
// then per level reads both children and compares/writes, and ends in the end state;
// sort time is set by the registered memory read in every level.
// Results stream one per cycle; ready again the cycle after the last.
// Reset is synchronous, active low; busy is high during reset. No clearing pass.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module heap_sort_records (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire [hsr_pkg::KEY_W-1:0]   in_sort_key,
  input  wire [hsr_pkg::TAG_W-1:0]   in_record_tag,
  input  wire                        in_final_item,
  output logic                       out_valid,
  output logic [hsr_pkg::KEY_W-1:0]  out_key,
  output logic [hsr_pkg::TAG_W-1:0]  out_tag,
  output logic                       out_last_result,
  output logic                       out_overflow_seen
);
  import hsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hsr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_final_item (in_final_item),
    .stat          (stat),
    .cmd           (cmd),
    .busy          (busy)
  );

  hsr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_sort_key       (in_sort_key),
    .in_record_tag     (in_record_tag),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_key           (out_key),
    .out_tag           (out_tag),
    .out_last_result   (out_last_result),
    .out_overflow_seen (out_overflow_seen)
  );

endmodule

`default_nettype wire

@@ hdl/hsr_checker.sv @@
// Port-level checker for heap_sort_records, attached by bind.
// Does not depend on hsr_pkg.
`default_nettype none

module hsr_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       start,
  input wire                       busy,
  input wire                       in_final_item,
  input wire                       out_valid,
  input wire                       out_last_result,
  input wire                       out_overflow_seen
);

  // Results only appear while a batch is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word outside a batch");

  // Flags travel only with a result word
  a_flags_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_last_result || out_overflow_seen) |-> out_valid)
    else $error("result flag without strobe");

  // A final word starts the sort
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_final_item) |=> busy)
    else $error("final word did not start the sort");

  // Nothing follows the last word of a batch
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |=> !out_valid)
    else $error("result word after the last one");

endmodule

bind heap_sort_records hsr_checker u_hsr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_final_item     (in_final_item),
  .out_valid         (out_valid),
  .out_last_result   (out_last_result),
  .out_overflow_seen (out_overflow_seen)
);

`default_nettype wire
